>>> rtl/escape_time_fractal_iterator_defines.svh
// Assertion helpers shared by the escape-time iterator RTL.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH

// Same-cycle implication, held off while reset is high.
`define ETF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off while reset is high.
`define ETF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/etf_pkg.sv
package etf_pkg;

   // Internal fixed point: signed Q.28 held in 40 bits
   localparam int INT_W  = 40;
   localparam int FRAC_W = 28;
   localparam int SUM_W  = INT_W + 1;

   // Multiplier operands carry 2*re, so one bit more than the internal width
   localparam int MUL_W  = INT_W + 1;
   localparam int HALF_W = 21;
   localparam int PP_W   = 2 * HALF_W;
   localparam int ACC_W  = 2 * MUL_W;
   localparam int MAG_W  = ACC_W - FRAC_W;

   typedef logic signed [INT_W-1:0] int_type;
   typedef logic signed [MUL_W-1:0] mul_op_type;

   localparam int_type SAT_MAX      = {1'b0, {(INT_W-1){1'b1}}};
   localparam int_type SAT_MIN      = {1'b1, {(INT_W-1){1'b0}}};
   localparam int_type ESCAPE_LIMIT = int_type'(4) <<< FRAC_W;

   // Clamp a sum that grew by one bit back into the internal range
   function automatic int_type sat_sum(input logic signed [SUM_W-1:0] v);
      int_type r;
      if (v > SUM_W'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (v < SUM_W'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = v[INT_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/etf_chan_if.sv
interface etf_req_if #(
   parameter int COORD_WIDTH = 32
);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] point_re;
   logic [COORD_WIDTH-1:0] point_im;

   modport source (output valid, output point_re, output point_im, input ready);
   modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

interface etf_rsp_if #(
   parameter int COUNT_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] iteration_count;

   modport source (output valid, output iteration_count, input ready);
   modport sink   (input valid, input iteration_count, output ready);
endinterface

>>> rtl/etf_mul.sv
`include "escape_time_fractal_iterator_defines.svh"

// Signed Q.28 multiply, saturated to 40 bits. One 21x21 partial product per cycle.
module etf_mul import etf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  mul_op_type op_a,
   input  mul_op_type op_b,
   output int_type    product,
   output logic       done
);

   logic             busy_ff, busy_in;
   logic             fin_ff, fin_in;
   logic [1:0]       step_ff, step_in;
   logic             neg_ff, neg_in;
   logic [MUL_W-1:0] mag_a_ff, mag_a_in;
   logic [MUL_W-1:0] mag_b_ff, mag_b_in;
   logic [ACC_W-1:0] acc_ff, acc_in;

   logic [HALF_W-1:0] part_a;
   logic [HALF_W-1:0] part_b;
   logic [PP_W-1:0]   pp;
   logic [ACC_W-1:0]  pp_aligned;
   logic [MAG_W-1:0]  mag;

   localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(SAT_MAX);

   always_comb begin
      part_a = step_ff[0] ? HALF_W'(mag_a_ff[MUL_W-1:HALF_W]) : mag_a_ff[HALF_W-1:0];
      part_b = step_ff[1] ? HALF_W'(mag_b_ff[MUL_W-1:HALF_W]) : mag_b_ff[HALF_W-1:0];
      pp     = PP_W'(part_a) * PP_W'(part_b);
      case (step_ff)
         2'b00:        pp_aligned = ACC_W'(pp);
         2'b01, 2'b10: pp_aligned = ACC_W'(pp) << HALF_W;
         default:      pp_aligned = ACC_W'(pp) << (2 * HALF_W);
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      step_in  = step_ff;
      neg_in   = neg_ff;
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         neg_in   = op_a[MUL_W-1] ^ op_b[MUL_W-1];
         mag_a_in = op_a[MUL_W-1] ? MUL_W'(-op_a) : MUL_W'(op_a);
         mag_b_in = op_b[MUL_W-1] ? MUL_W'(-op_b) : MUL_W'(op_b);
         acc_in   = '0;
      end else if (busy_ff) begin
         acc_in  = acc_ff + pp_aligned;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         step_ff <= step_in;
      end
      neg_ff   <= neg_in;
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      acc_ff   <= acc_in;
   end

   // Drop the fraction bits (truncation toward zero on the magnitude), then sign and clamp
   always_comb begin
      mag = acc_ff[ACC_W-1:FRAC_W];
      if (mag > MAG_LIMIT) begin
         product = neg_ff ? SAT_MIN : SAT_MAX;
      end else if (neg_ff) begin
         product = -int_type'(mag[INT_W-1:0]);
      end else begin
         product = int_type'(mag[INT_W-1:0]);
      end
   end

   assign done = fin_ff;

   `ETF_ASSERT_IMPLY(a_start_when_free, clock, reset, start, !busy_ff && !fin_ff, "multiply started while busy")
   `ETF_ASSERT_NEXT(a_last_pass_finishes, clock, reset, busy_ff && step_ff == 2'd3, fin_ff && !busy_ff, "last partial product did not finish")
   `ETF_ASSERT_IMPLY(a_fin_not_busy, clock, reset, fin_ff, !busy_ff, "result flagged while still accumulating")

endmodule

>>> rtl/escape_time_fractal_iterator.sv
// Escape-time iterator for Mandelbrot and Julia sets. Each req_chan transaction
// carries one point (signed Q4.28); the block answers with one rsp_chan
// transaction holding the number of iterations of z = z^2 + c run before
// |z|^2 exceeds 4, capped at max_iterations (a cap of zero answers zero).
// fractal_mode 0 starts z at zero with c = point; mode 1 starts z at the point
// with c = (julia_c_re, julia_c_im). Internal values are Q.28 in 40 bits and
// saturate. Registers sit on the APB port at byte address 4*i (8*i when
// COORD_WIDTH exceeds 32): mode, max_iterations, julia_c_re, julia_c_im.
// Write them only while no point is in flight. The default cap is 100.
// Iteration time is set by the single shared 21x21 multiplier: each Q.28
// product takes four partial-product passes, and each iteration needs three
// products (re^2, im^2, 2*re*im). req_chan.ready is high only between points;
// a finished count waits in the output register, so the next point may be
// taken while the previous count is still pending.
`include "escape_time_fractal_iterator_defines.svh"

module escape_time_fractal_iterator import etf_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int COUNT_WIDTH = 16,
   localparam int DATA_W  = (COORD_WIDTH > 32) ? 64 : 32,
   localparam int IDX_LSB = (COORD_WIDTH > 32) ? 3 : 2,
   localparam int ADDR_W  = IDX_LSB + 2
) (
   input  logic              clock,
   input  logic              reset,
   etf_req_if.sink           req_chan,
   etf_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int EXT_W = (COORD_WIDTH > INT_W) ? COORD_WIDTH : INT_W;
   localparam logic signed [EXT_W-1:0] EXT_MAX = EXT_W'(SAT_MAX);
   localparam logic signed [EXT_W-1:0] EXT_MIN = EXT_W'(SAT_MIN);

   localparam logic [1:0] REG_MODE     = 2'd0;
   localparam logic [1:0] REG_MAX_ITER = 2'd1;
   localparam logic [1:0] REG_C_RE     = 2'd2;
   localparam logic [1:0] REG_C_IM     = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_CHECK,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_SQ_RE,
      OP_SQ_IM,
      OP_CROSS
   } op_type;

   // Sign-extend a coordinate, then clamp into the internal range
   function automatic int_type coord_sat(input logic [COORD_WIDTH-1:0] raw);
      logic signed [EXT_W-1:0] ext;
      int_type r;
      ext = EXT_W'(signed'(raw));
      if (ext > EXT_MAX) begin
         r = SAT_MAX;
      end else if (ext < EXT_MIN) begin
         r = SAT_MIN;
      end else begin
         r = ext[INT_W-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic                   mode_ff;
   logic [COUNT_WIDTH-1:0] max_iter_ff;
   logic [COORD_WIDTH-1:0] c_re_ff;
   logic [COORD_WIDTH-1:0] c_im_ff;
   logic [1:0]             csr_idx;
   logic                   csr_write;

   assign pready    = 1'b1;
   assign csr_idx   = paddr[ADDR_W-1:IDX_LSB];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         max_iter_ff <= COUNT_WIDTH'(100);
         c_re_ff     <= '0;
         c_im_ff     <= '0;
      end else if (csr_write) begin
         case (csr_idx)
            REG_MODE:     mode_ff     <= pwdata[0];
            REG_MAX_ITER: max_iter_ff <= pwdata[COUNT_WIDTH-1:0];
            REG_C_RE:     c_re_ff     <= pwdata[COORD_WIDTH-1:0];
            REG_C_IM:     c_im_ff     <= pwdata[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_MODE:     prdata = DATA_W'(mode_ff);
         REG_MAX_ITER: prdata = DATA_W'(max_iter_ff);
         REG_C_RE:     prdata = DATA_W'(signed'(c_re_ff));
         REG_C_IM:     prdata = DATA_W'(signed'(c_im_ff));
         default:      prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Iteration datapath and sequencer
   // ---------------------------------------------------------------
   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic                   mul_start_ff, mul_start_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   int_type                zr_ff, zr_in;
   int_type                zi_ff, zi_in;
   int_type                cr_ff, cr_in;
   int_type                ci_ff, ci_in;
   int_type                r2_ff, r2_in;
   int_type                i2_ff, i2_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   mul_op_type mul_a;
   mul_op_type mul_b;
   int_type    mul_product;
   logic       mul_done;
   int_type    point_re;
   int_type    point_im;
   int_type    mag2;
   int_type    re_diff;
   logic       req_take;
   logic       rsp_free;

   assign point_re = coord_sat(COORD_WIDTH'(req_chan.point_re));
   assign point_im = coord_sat(COORD_WIDTH'(req_chan.point_im));
   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // |z|^2 for the escape test and the real-part difference, both clamped
   assign mag2    = sat_sum(SUM_W'(r2_ff) + SUM_W'(i2_ff));
   assign re_diff = sat_sum(SUM_W'(r2_ff) - SUM_W'(i2_ff));

   // Operand select for the shared multiplier; the cross term doubles re
   always_comb begin
      case (op_ff)
         OP_SQ_RE: begin
            mul_a = MUL_W'(zr_ff);
            mul_b = MUL_W'(zr_ff);
         end
         OP_SQ_IM: begin
            mul_a = MUL_W'(zi_ff);
            mul_b = MUL_W'(zi_ff);
         end
         OP_CROSS: begin
            mul_a = {zr_ff, 1'b0};
            mul_b = MUL_W'(zi_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   etf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_product),
      .done    (mul_done)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      mul_start_in = 1'b0;
      count_in     = count_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      r2_in        = r2_ff;
      i2_in        = i2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_count_in = rsp_count_ff;

      case (state_ff)
         S_IDLE: begin
            // Load the start point and constant, then square z
            if (req_take) begin
               count_in     = '0;
               op_in        = OP_SQ_RE;
               mul_start_in = 1'b1;
               state_in     = S_MUL;
               if (mode_ff) begin
                  zr_in = point_re;
                  zi_in = point_im;
                  cr_in = coord_sat(c_re_ff);
                  ci_in = coord_sat(c_im_ff);
               end else begin
                  zr_in = '0;
                  zi_in = '0;
                  cr_in = point_re;
                  ci_in = point_im;
               end
            end
         end
         S_MUL: begin
            if (mul_done) begin
               case (op_ff)
                  OP_SQ_RE: begin
                     r2_in        = mul_product;
                     op_in        = OP_SQ_IM;
                     mul_start_in = 1'b1;
                  end
                  OP_SQ_IM: begin
                     i2_in    = mul_product;
                     state_in = S_CHECK;
                  end
                  OP_CROSS: begin
                     // New imaginary part uses the old real part; advance z together
                     zi_in        = sat_sum(SUM_W'(mul_product) + SUM_W'(ci_ff));
                     zr_in        = sat_sum(SUM_W'(re_diff) + SUM_W'(cr_ff));
                     count_in     = count_ff + 1'b1;
                     op_in        = OP_SQ_RE;
                     mul_start_in = 1'b1;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (mag2 <= ESCAPE_LIMIT && count_ff < max_iter_ff) begin
               op_in        = OP_CROSS;
               mul_start_in = 1'b1;
               state_in     = S_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hold the count until the output register frees up
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_SQ_RE;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         mul_start_ff <= mul_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff     <= count_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      r2_ff        <= r2_in;
      i2_ff        <= i2_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_chan.ready           = (state_ff == S_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.iteration_count = rsp_count_ff;

   `ETF_ASSERT_IMPLY(a_count_capped, clock, reset, state_ff != S_IDLE, count_ff <= max_iter_ff, "iteration count passed the cap")
   `ETF_ASSERT_NEXT(a_accept_starts_mul, clock, reset, req_take, mul_start_ff && state_ff == S_MUL, "accepted point did not start a multiply")
   `ETF_ASSERT_IMPLY(a_done_in_mul, clock, reset, mul_done, state_ff == S_MUL && !mul_start_ff, "multiplier result outside the multiply phase")

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the escape-time iterator: points go in on req_chan, iteration
// counts come back on rsp_chan, and every count is checked against a local
// fixed-point predictor that tracks the register settings written over APB.
module tb_top;

   localparam int IDLE_PCT    = 27;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int TAIL_CYCLES = 2000;
   localparam int MAX_REPORTS = 10;

   // Register indexes on the configuration port (byte address = 4 * index)
   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_CAP  = 2'd1;
   localparam logic [1:0] REG_C_RE = 2'd2;
   localparam logic [1:0] REG_C_IM = 2'd3;

   // Handy Q4.28 values
   localparam int Q_TWO     = 32'sh2000_0000;
   localparam int Q_NEG_TWO = -32'sh2000_0000;
   localparam int Q_MAX     = 32'sh7FFF_FFFF;
   localparam int Q_MIN     = 32'sh8000_0000;

   // Predictor arithmetic: Q.28 in 40 bits, with headroom for sums and 2*re
   typedef logic signed [39:0] fix_t;
   typedef logic signed [47:0] wide_t;

   localparam fix_t FIX_MAX      = {1'b0, {39{1'b1}}};
   localparam fix_t FIX_MIN      = {1'b1, {39{1'b0}}};
   localparam fix_t ESCAPE_RADSQ = 40'sh00_4000_0000;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
   } point_t;

   typedef struct packed {
      point_t      pt;
      logic [15:0] count;
   } count_due_t;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   etf_req_if #(.COORD_WIDTH(32)) req_chan ();
   etf_rsp_if #(.COUNT_WIDTH(16)) rsp_chan ();

   escape_time_fractal_iterator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Shadow copy of the block's registers, updated as each write completes
   bit          julia_mode;
   logic [15:0] iter_cap;
   fix_t        c_re;
   fix_t        c_im;

   point_t      points_pending[$];
   count_due_t  counts_due[$];
   bit          req_taken;
   bit          steady;
   int          fail_count;
   int          cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Clamp a widened value back into the signed 40-bit range
   function automatic fix_t clamp40(input wide_t v);
      if (v > wide_t'(FIX_MAX)) begin
         return FIX_MAX;
      end
      if (v < wide_t'(FIX_MIN)) begin
         return FIX_MIN;
      end
      return v[39:0];
   endfunction

   // Q.28 product: truncate the magnitude toward zero, then apply the sign
   // and saturate
   function automatic fix_t q28_mul(input wide_t a, input wide_t b);
      logic [47:0] mag_a;
      logic [47:0] mag_b;
      logic [95:0] prod;
      logic        neg;
      neg   = (a < 0) != (b < 0);
      mag_a = (a < 0) ? -a : a;
      mag_b = (b < 0) ? -b : b;
      prod  = ({48'd0, mag_a} * {48'd0, mag_b}) >> 28;
      if (neg) begin
         return (prod >= (96'd1 << 39)) ? FIX_MIN : -fix_t'(prod[39:0]);
      end
      return (prod > 96'(FIX_MAX)) ? FIX_MAX : fix_t'(prod[39:0]);
   endfunction

   // Iterations of z = z^2 + c before |z|^2 exceeds 4, capped at iter_cap
   function automatic logic [15:0] escape_count(input logic [31:0] pre,
                                                input logic [31:0] pim);
      fix_t        p_re;
      fix_t        p_im;
      fix_t        zr;
      fix_t        zi;
      fix_t        cr;
      fix_t        ci;
      fix_t        r2;
      fix_t        i2;
      wide_t       twice_re;
      logic [16:0] n;
      p_re = fix_t'($signed(pre));
      p_im = fix_t'($signed(pim));
      if (julia_mode) begin
         zr = p_re;
         zi = p_im;
         cr = c_re;
         ci = c_im;
      end else begin
         zr = '0;
         zi = '0;
         cr = p_re;
         ci = p_im;
      end
      r2 = q28_mul(zr, zr);
      i2 = q28_mul(zi, zi);
      n  = '0;
      while (clamp40(wide_t'(r2) + wide_t'(i2)) <= ESCAPE_RADSQ && n < iter_cap) begin
         // the imaginary part must use the old real part
         twice_re = wide_t'(zr) <<< 1;
         zi = clamp40(wide_t'(q28_mul(twice_re, zi)) + wide_t'(ci));
         zr = clamp40(wide_t'(clamp40(wide_t'(r2) - wide_t'(i2))) + wide_t'(cr));
         r2 = q28_mul(zr, zr);
         i2 = q28_mul(zi, zi);
         n++;
      end
      return n[15:0];
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Mostly points inside |re|, |im| <= 2 where orbits last, the rest raw bits
   function automatic int rand_coord();
      if ($urandom_range(99) < 70) begin
         return int'($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
      end
      return int'($urandom);
   endfunction

   task automatic queue_point(input int re, input int im);
      point_t p;
      p.re = re;
      p.im = im;
      points_pending.push_back(p);
   endtask

   // Hold until every queued point has gone out and every count has come back
   task automatic drain();
      do begin
         @(negedge clock);
      end while (points_pending.size() != 0 || req_chan.valid || counts_due.size() != 0);
      @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; the register takes the value
   // at the rising edge of the access cycle
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_MODE: julia_mode = data[0];
         REG_CAP:  iter_cap   = data[15:0];
         REG_C_RE: c_re       = fix_t'($signed(data));
         REG_C_IM: c_im       = fix_t'($signed(data));
         default: ;
      endcase
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: change at the falling edge, hold until the transaction
   // is taken, idle at random unless a steady stretch is running
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      point_t nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (points_pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            nxt = points_pending.pop_front();
            req_chan.valid    <= 1'b1;
            req_chan.point_re <= nxt.re;
            req_chan.point_im <= nxt.im;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin : rsp_stall
      rsp_chan.ready <= !reset && (steady || $urandom_range(99) >= IDLE_PCT);
   end

   // ---------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge; compare each result
   // before recording a point taken at the same edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      count_due_t due;
      count_due_t fresh;
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d counts outstanding",
                  cycles, counts_due.size());
         $display("Test completed with failures");
         $finish;
      end else if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (counts_due.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("unexpected iteration_count %0d with no point outstanding",
                           rsp_chan.iteration_count);
               end
            end else begin
               due = counts_due.pop_front();
               if (rsp_chan.iteration_count !== due.count) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("iteration_count mismatch for point (%h, %h): expected %0d, got %0d",
                              due.pt.re, due.pt.im, due.count, rsp_chan.iteration_count);
                  end
               end
            end
         end
         req_taken = req_chan.valid && req_chan.ready;
         if (req_taken) begin
            fresh.pt.re = req_chan.point_re;
            fresh.pt.im = req_chan.point_im;
            fresh.count = escape_count(req_chan.point_re, req_chan.point_im);
            counts_due.push_back(fresh);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int phase;
      int k;
      logic [15:0] cap;

      // known values on every input from time zero
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_chan.valid    = 1'b0;
      req_chan.point_re = '0;
      req_chan.point_im = '0;
      rsp_chan.ready    = 1'b0;
      steady            = 1'b0;
      fail_count        = 0;
      cycles            = 0;

      // reset values of the registers
      julia_mode = 1'b0;
      iter_cap   = 16'd100;
      c_re       = '0;
      c_im       = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Mandelbrot at reset defaults: origin and -2 never escape, 2 sits
      // exactly on the radius for one pass, corners escape at once
      queue_point(0, 0);
      queue_point(Q_TWO, 0);
      queue_point(Q_NEG_TWO, 0);
      queue_point(32'sd67108864, 0);        // 0.25, cusp of the cardioid
      queue_point(Q_MAX, Q_MAX);
      queue_point(Q_MIN, Q_MIN);
      queue_point(Q_MAX, Q_MIN);
      queue_point(Q_MIN, Q_MAX);
      drain();

      // zero cap in Julia mode with the constant at its extremes
      csr_write(REG_MODE, 32'd1);
      csr_write(REG_CAP, 32'd0);
      csr_write(REG_C_RE, Q_MAX);
      csr_write(REG_C_IM, Q_MIN);
      queue_point(0, 0);
      queue_point(Q_MAX, Q_MIN);
      drain();

      // extreme constant with a nonzero cap: the origin escapes after one step, the corner at once
      csr_write(REG_CAP, 32'd20);
      queue_point(0, 0);
      queue_point(Q_MIN, Q_MAX);
      drain();

      // classic Julia constant -0.8 + 0.156i; upper mode bits must not matter
      csr_write(REG_MODE, 32'hFFFF_FFFF);
      csr_write(REG_C_RE, -32'sd214748365);
      csr_write(REG_C_IM, 32'sd41875931);
      queue_point(0, 0);
      queue_point(32'sd80530637, -32'sd134217728);
      queue_point(Q_MIN, Q_MIN);
      drain();

      // largest cap, Mandelbrot: only points that escape in a few dozen steps
      csr_write(REG_MODE, 32'hFFFF_FFFE);
      csr_write(REG_CAP, 32'h0000_FFFF);
      queue_point(32'sd69793218, 0);        // 0.26, just off the cardioid
      queue_point(0, Q_NEG_TWO);
      queue_point(Q_MAX, Q_MAX);
      queue_point(Q_MIN, 0);
      drain();

      // cap of one in both modes
      csr_write(REG_CAP, 32'd1);
      queue_point(0, 0);
      queue_point(Q_MAX, Q_MAX);
      drain();
      csr_write(REG_MODE, 32'd1);
      queue_point(Q_MAX, Q_MAX);
      queue_point(0, 0);
      drain();

      // random phases: fresh settings each time, one phase with no idling
      for (phase = 0; phase < 6; phase++) begin
         drain();
         steady = (phase == 2);
         cap    = 16'($urandom_range(40));
         csr_write(REG_MODE, ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(1)));
         csr_write(REG_CAP, ($urandom & 32'hFFFF_0000) | 32'(cap));
         csr_write(REG_C_RE, rand_coord());
         csr_write(REG_C_IM, rand_coord());
         for (k = 0; k < 125; k++) begin
            queue_point(rand_coord(), rand_coord());
         end
      end

      // let the last counts land, then watch for strays
      drain();
      steady = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
